/* rtl/core/xor_key_stream_matcher_top_assert.svh */
// assertion macros for the key stream matcher
`ifndef XOR_KEY_STREAM_MATCHER_TOP_ASSERT_SVH
`define XOR_KEY_STREAM_MATCHER_TOP_ASSERT_SVH

// same-cycle implication
`define XKM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XKM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/xkm_pkg.sv */
package xkm_pkg;

    localparam int KEY_BYTES = 32;
    localparam int KIDX_W    = 5;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_EXACT = 2'd1;
    localparam logic [1:0] MODE_XOR   = 2'd2;

    localparam logic [2:0] REG_CHECK_MODE = 3'd0;
    localparam logic [2:0] REG_KEY_LENGTH = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_0 = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_1 = 3'd3;
    localparam logic [2:0] REG_KEY_WORD_2 = 3'd4;
    localparam logic [2:0] REG_KEY_WORD_3 = 3'd5;

    typedef logic [KEY_BYTES-1:0][7:0] key_bytes_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_t;

    typedef struct packed {
        logic key_found;
        logic buffer_done;
    } out_t;

    typedef struct packed {
        logic [1:0]       check_mode;
        logic [5:0]       key_length;
        logic [3:0][63:0] key_word;
    } cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

/* rtl/core/xkm_cfg.sv */
module xkm_cfg
    import xkm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[5:3])
                REG_CHECK_MODE: cfg_next.check_mode  = pwdata[1:0];
                REG_KEY_LENGTH: cfg_next.key_length  = pwdata[5:0];
                REG_KEY_WORD_0: cfg_next.key_word[0] = pwdata;
                REG_KEY_WORD_1: cfg_next.key_word[1] = pwdata;
                REG_KEY_WORD_2: cfg_next.key_word[2] = pwdata;
                REG_KEY_WORD_3: cfg_next.key_word[3] = pwdata;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_CHECK_MODE: prdata = {62'd0, cfg_reg.check_mode};
            REG_KEY_LENGTH: prdata = {58'd0, cfg_reg.key_length};
            REG_KEY_WORD_0: prdata = cfg_reg.key_word[0];
            REG_KEY_WORD_1: prdata = cfg_reg.key_word[1];
            REG_KEY_WORD_2: prdata = cfg_reg.key_word[2];
            REG_KEY_WORD_3: prdata = cfg_reg.key_word[3];
            default:        prdata = '0;
        endcase
    end

    // all fields reset to zero, which leaves check_mode at MODE_OFF
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/xkm_cell.sv */
module xkm_cell
    import xkm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctl_t         ctl,
    input  logic [7:0]        byte_in,
    input  key_bytes_t        key_bytes,
    input  logic [KIDX_W-1:0] kidx,
    input  logic              kuse,
    input  logic              exact,
    input  logic [7:0]        diff_in,
    input  logic              use_in,
    output logic [7:0]        byte_out,
    output logic [7:0]        diff_out,
    output logic              use_out,
    output logic              ok
);

    logic [7:0] win_reg;
    logic [7:0] win_next;
    logic [7:0] akey_reg;
    logic [7:0] akey_next;
    logic       use_reg;
    logic       use_next;

    always_comb
    begin
        win_next = win_reg;
        if (ctl.shift)
        begin
            win_next = ctl.clear ? 8'd0 : byte_in;
        end
        akey_next = key_bytes[kidx];
        use_next  = kuse;
    end

    assign byte_out = win_reg;
    assign diff_out = win_reg ^ akey_reg;
    assign use_out  = use_reg;
    assign ok = !use_reg || (exact ? (diff_out == 8'd0) : (!use_in || diff_out == diff_in));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= 8'd0;
            use_reg <= 1'b0;
        end
        else
        begin
            win_reg <= win_next;
            use_reg <= use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        akey_reg <= akey_next;
    end

endmodule

/* rtl/core/xor_key_stream_matcher_top.sv */
// Key stream matcher: accepts one buffer byte per clock cycle unless in_stall is high, and
// returns one result per byte through the v1 stage and the output register, carrying the
// sticky key_found flag for the buffer and an echo of buffer_end. The rate is set by the row
// of KEY_MAX window cells, which shifts by one byte on each accepted byte and xors every
// window byte with its aligned key byte in parallel. Configuration goes through the APB port
// at byte address 8*i and takes effect for the next byte transferred.
`include "xor_key_stream_matcher_top_assert.svh"

module xor_key_stream_matcher_top
    import xkm_pkg::*;
#(
    parameter int KEY_MAX = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_t               in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_t              out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int FILL_W = $clog2(KEY_MAX + 1);

    cfg_t                     cfg;
    key_bytes_t               key_bytes;
    logic                     exact;
    logic [KEY_MAX-1:0][7:0]  byte_chain;
    logic [KEY_MAX-1:0][7:0]  diff_chain;
    logic [KEY_MAX-1:0]       use_chain;
    logic [KEY_MAX-1:0]       ok_vec;

    logic              accept;
    logic              adv;
    logic              hit;
    logic              mode_ok;
    logic              len_ok;
    logic              fill_ok;
    logic              found_now;
    logic [FILL_W-1:0] fill_base;

    logic              v1_reg;
    logic              v1_next;
    logic              last1_reg;
    logic              last1_next;
    logic              fresh_reg;
    logic              fresh_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              found_reg;
    logic              found_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    out_t              out_reg;
    out_t              out_next;

    xkm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign key_bytes = cfg.key_word;
    assign exact     = (cfg.check_mode == MODE_EXACT);

    assign adv      = v1_reg & (!out_valid_reg | !out_stall);
    assign in_stall = v1_reg & !adv;
    assign accept   = in_valid & !in_stall;

    for (genvar j = 0; j < KEY_MAX; j++)
    begin : g_cell
        cell_ctl_t         ctl;
        logic [7:0]        byte_in;
        logic [7:0]        diff_in;
        logic              use_in;
        logic [KIDX_W-1:0] kidx;
        logic              kuse;

        if (j == 0)
        begin : g_head
            assign byte_in = in_data.data_byte;
            assign ctl     = '{shift: accept, clear: 1'b0};
        end
        else
        begin : g_body
            assign byte_in = byte_chain[j-1];
            assign ctl     = '{shift: accept, clear: fresh_reg};
        end

        if (j == KEY_MAX - 1)
        begin : g_tail
            assign diff_in = 8'd0;
            assign use_in  = 1'b0;
        end
        else
        begin : g_mid
            assign diff_in = diff_chain[j+1];
            assign use_in  = use_chain[j+1];
        end

        assign kidx = KIDX_W'(cfg.key_length - 6'(j) - 6'd1);
        assign kuse = (cfg.key_length > 6'(j));

        xkm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .byte_in   (byte_in),
            .key_bytes (key_bytes),
            .kidx      (kidx),
            .kuse      (kuse),
            .exact     (exact),
            .diff_in   (diff_in),
            .use_in    (use_in),
            .byte_out  (byte_chain[j]),
            .diff_out  (diff_chain[j]),
            .use_out   (use_chain[j]),
            .ok        (ok_vec[j])
        );
    end

    assign mode_ok   = cfg.check_mode inside {MODE_EXACT, MODE_XOR};
    assign len_ok    = (cfg.key_length != 6'd0) && (cfg.key_length <= 6'(KEY_MAX));
    assign fill_ok   = (7'(fill_reg) >= 7'(cfg.key_length));
    assign hit       = mode_ok & len_ok & fill_ok & (&ok_vec);
    assign found_now = found_reg | hit;
    assign fill_base = fresh_reg ? '0 : fill_reg;

    always_comb
    begin
        v1_next    = v1_reg;
        last1_next = last1_reg;
        fresh_next = fresh_reg;
        fill_next  = fill_reg;
        if (accept)
        begin
            v1_next    = 1'b1;
            last1_next = in_data.buffer_end;
            fresh_next = in_data.buffer_end;
            fill_next  = (fill_base == FILL_W'(KEY_MAX)) ? fill_base : fill_base + 1'b1;
        end
        else if (adv)
        begin
            v1_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        found_next     = found_reg;
        if (adv)
        begin
            out_valid_next       = 1'b1;
            out_next.key_found   = found_now;
            out_next.buffer_done = last1_reg;
            found_next           = last1_reg ? 1'b0 : found_now;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            last1_reg     <= 1'b0;
            fresh_reg     <= 1'b0;
            fill_reg      <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            last1_reg     <= last1_next;
            fresh_reg     <= fresh_next;
            fill_reg      <= fill_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `XKM_ASSERT_NOW(a_stall_cause, in_stall, v1_reg && out_valid_reg && out_stall, "stall without full pipe")
    `XKM_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_reg, "result lost on advance")
    `XKM_ASSERT_NEXT(a_end_restarts, accept && in_data.buffer_end, fresh_reg, "buffer end not marked")
    `XKM_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(KEY_MAX), "fill count overflow")

endmodule

/* sim/tb_xor_key_stream_matcher_top.sv */
`timescale 1ns / 1ps

module tb_xor_key_stream_matcher_top;
    import xkm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int SEGMENT_BYTES = 72;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    in_t byte_q[$];
    out_t verdict_q[$];
    out_t oldest;

    cfg_t shadow_cfg = '0;
    logic [7:0] byte_hist [KEY_BYTES];
    int bytes_in_window = 0;
    bit key_seen = 1'b0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;

    int errors = 0;
    int cycles = 0;
    int queued_total = 0;
    int results_checked = 0;
    int buffers_closed = 0;
    int buffers_hit = 0;
    int reg_writes = 0;

    xor_key_stream_matcher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [7:0] key_byte(int i);
        return shadow_cfg.key_word[i / 8][8 * (i % 8) +: 8];
    endfunction

    function automatic bit key_hits_window();
        int len;
        int i;
        logic [7:0] pad;
        len = shadow_cfg.key_length;
        if (shadow_cfg.check_mode != MODE_EXACT && shadow_cfg.check_mode != MODE_XOR)
            return 1'b0;
        if (len == 0 || len > KEY_BYTES)
            return 1'b0;
        if (bytes_in_window < len)
            return 1'b0;
        pad = byte_hist[len - 1] ^ key_byte(0);
        if (shadow_cfg.check_mode == MODE_EXACT && pad != 8'h00)
            return 1'b0;
        for (i = 1; i < len; i++)
        begin
            if ((byte_hist[len - 1 - i] ^ key_byte(i)) != pad)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void advance_window(in_t t);
        out_t v;
        int i;
        for (i = KEY_BYTES - 1; i > 0; i--)
            byte_hist[i] = byte_hist[i - 1];
        byte_hist[0] = t.data_byte;
        if (bytes_in_window < KEY_BYTES)
            bytes_in_window++;
        if (key_hits_window())
            key_seen = 1'b1;
        v.key_found = key_seen;
        v.buffer_done = t.buffer_end;
        verdict_q.push_back(v);
        if (t.buffer_end)
        begin
            for (i = 0; i < KEY_BYTES; i++)
                byte_hist[i] = 8'h00;
            bytes_in_window = 0;
            key_seen = 1'b0;
        end
    endfunction

    // input side: one transfer per accepted byte
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_window(in_data);
            if (!in_valid || !in_stall)
            begin
                if (byte_q.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_data <= byte_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output side: check each transfer, then pick the next stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: result with nothing expected, actual %b", $time, out_data);
                    errors++;
                end
                else
                begin
                    oldest = verdict_q.pop_front();
                    results_checked++;
                    if (oldest.buffer_done)
                    begin
                        buffers_closed++;
                        if (oldest.key_found)
                            buffers_hit++;
                    end
                    if (out_data.key_found !== oldest.key_found)
                    begin
                        $display("%0t: key_found expected %b actual %b",
                                 $time, oldest.key_found, out_data.key_found);
                        errors++;
                    end
                    if (out_data.buffer_done !== oldest.buffer_done)
                    begin
                        $display("%0t: buffer_done expected %b actual %b",
                                 $time, oldest.buffer_done, out_data.buffer_done);
                        errors++;
                    end
                end
            end
            if (hold_ack != hold_req)
            begin
                hold_ack <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        reg_writes++;
        case (idx)
            REG_CHECK_MODE: shadow_cfg.check_mode = value[1:0];
            REG_KEY_LENGTH: shadow_cfg.key_length = value[5:0];
            REG_KEY_WORD_0: shadow_cfg.key_word[0] = value;
            REG_KEY_WORD_1: shadow_cfg.key_word[1] = value;
            REG_KEY_WORD_2: shadow_cfg.key_word[2] = value;
            REG_KEY_WORD_3: shadow_cfg.key_word[3] = value;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [1:0] mode, logic [5:0] len, logic [63:0] k0,
                              logic [63:0] k1, logic [63:0] k2, logic [63:0] k3);
        write_reg(REG_CHECK_MODE, 64'(mode));
        write_reg(REG_KEY_LENGTH, 64'(len));
        write_reg(REG_KEY_WORD_0, k0);
        write_reg(REG_KEY_WORD_1, k1);
        write_reg(REG_KEY_WORD_2, k2);
        write_reg(REG_KEY_WORD_3, k3);
    endtask

    task automatic push_byte(logic [7:0] b, logic last);
        in_t t;
        t.data_byte = b;
        t.buffer_end = last;
        byte_q.push_back(t);
        queued_total++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
    endtask

    function automatic logic [63:0] random_word();
        return ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
    endfunction

    task automatic pick_config(int seg);
        logic [1:0] mode;
        logic [5:0] len;
        int r;
        r = $urandom_range(99);
        if (r < 42)
            mode = MODE_EXACT;
        else if (r < 84)
            mode = MODE_XOR;
        else if (r < 92)
            mode = MODE_OFF;
        else
            mode = MODE_RESERVED;
        r = $urandom_range(9);
        if (r == 0)
            len = ($urandom_range(1) == 0) ? 6'd0 : 6'($urandom_range(33, 63));
        else if (r == 1)
            len = 6'd32;
        else
            len = 6'($urandom_range(1, 12));
        case (seg)
            0: begin mode = MODE_EXACT; len = 6'd32; end
            1: begin mode = MODE_XOR; len = 6'd1; end
            2: begin mode = MODE_XOR; len = 6'd32; end
            3: begin mode = MODE_EXACT; len = 6'd1; end
            default: ;
        endcase
        set_config(mode, len, random_word(), random_word(), random_word(), random_word());
    endtask

    // one buffer: random lead-in (which may itself end buffers), often the key (xored or corrupted), random tail
    task automatic queue_random_buffer();
        int plen;
        int lead;
        int trail;
        int kind;
        int flip;
        int i;
        logic [7:0] pad;
        logic [7:0] err;
        plen = (shadow_cfg.key_length > KEY_BYTES) ? KEY_BYTES : shadow_cfg.key_length;
        lead = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        trail = ($urandom_range(4) == 0) ? $urandom_range(20) : $urandom_range(3);
        kind = $urandom_range(9);
        flip = (plen > 0) ? $urandom_range(plen - 1) : 0;
        if (shadow_cfg.check_mode == MODE_EXACT && $urandom_range(3) != 0)
            pad = 8'h00;
        else
            pad = 8'($urandom);
        repeat (lead)
            push_byte(8'($urandom), $urandom_range(19) == 0);
        if (kind < 8)
        begin
            for (i = 0; i < plen; i++)
            begin
                err = (kind >= 6 && i == flip) ? 8'(1 << $urandom_range(7)) : 8'h00;
                push_byte(key_byte(i) ^ pad ^ err, 1'b0);
            end
        end
        repeat (trail)
            push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b1);
    endtask

    task automatic fill_segment(int n);
        int start;
        start = queued_total;
        while (queued_total - start < n)
            queue_random_buffer();
    endtask

    initial
    begin
        int ph;
        int s;
        int seg;
        int i;
        for (i = 0; i < KEY_BYTES; i++)
            byte_hist[i] = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: no check
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // exact key "ABC": short buffer, then a hit that stays set
        set_config(MODE_EXACT, 6'd3, 64'h0000_0000_0043_4241, '0, '0, '0);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b1);
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h43, 1'b0);
        wait_idle();

        // switching checks off mid buffer keeps the flag
        write_reg(REG_CHECK_MODE, 64'(MODE_OFF));
        push_byte(8'h11, 1'b0);
        push_byte(8'h41, 1'b1);
        wait_idle();

        // reserved mode matches nothing
        write_reg(REG_CHECK_MODE, 64'(MODE_RESERVED));
        push_byte(8'h41, 1'b0);
        push_byte(8'h42, 1'b0);
        push_byte(8'h43, 1'b1);
        wait_idle();

        // xor mode with extreme key bytes
        set_config(MODE_XOR, 6'd2, 64'h0000_0000_0000_FF00, '1, '1, '1);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        wait_idle();

        // zero length and overlong key
        write_reg(REG_KEY_LENGTH, 64'd0);
        push_byte(8'h00, 1'b1);
        wait_idle();
        set_config(MODE_EXACT, 6'd63, '0, '0, '0, '0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        seg = 0;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
                1: begin sender_idle_pct = 51; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 51; end
                default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
            endcase
            for (s = 0; s < 2; s++)
            begin
                pick_config(seg);
                fill_segment(SEGMENT_BYTES);
                wait_idle();
                seg++;
            end
        end

        // long receiver hold while the sender keeps offering
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        pick_config(seg);
        hold_req++;
        fill_segment(SEGMENT_BYTES);
        wait_idle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("checked %0d results over %0d buffers, key found in %0d", results_checked,
                 buffers_closed, buffers_hit);
        $display("%0d register writes, exact/xor/off modes with keys of 0 to 63 bytes",
                 reg_writes);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* xor_key_stream_matcher_top.f */
+incdir+rtl/core
rtl/core/xkm_pkg.sv
rtl/core/xkm_cfg.sv
rtl/core/xkm_cell.sv
rtl/core/xor_key_stream_matcher_top.sv
sim/tb_xor_key_stream_matcher_top.sv
